>>> rtl/hsce_pkg.sv
package hsce_pkg;

    // UTF-8 lead byte and non-breaking space byte
    localparam logic [7:0] LEAD_BYTE = 8'hC2;
    localparam logic [7:0] NBSP_BYTE = 8'hA0;

    // Characters that are escaped
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;
    localparam logic [7:0] CHR_LT     = 8'h3C;
    localparam logic [7:0] CHR_GT     = 8'h3E;
    localparam logic [7:0] CHR_AMP    = 8'h26;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_DQUOTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_SQUOTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UTF8_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_NBSP   = 3'd3;

    // Widest run (held lead byte plus six-byte entity), and width of a run length
    localparam int ENT_MAX_BYTES = 7;
    localparam int RUN_LEN_W     = 3;

    // What one byte turns into, apart from a flushed lead byte
    typedef enum logic [2:0] {
        ENT_NONE,
        ENT_PLAIN,
        ENT_QUOT,
        ENT_APOS,
        ENT_LT,
        ENT_GT,
        ENT_AMP,
        ENT_NBSP
    } entity_t;

    typedef struct packed {
        logic esc_dquote;
        logic esc_squote;
        logic utf8_mode;
        logic esc_nbsp;
    } cfg_t;

    // Item sitting in the input register, plus the held lead byte flag
    typedef struct packed {
        logic [7:0] text_byte;
        logic       string_last;
        logic       held;
    } item_t;

    // Output run for one item
    typedef struct packed {
        logic                 lead;
        entity_t              ent;
        logic [RUN_LEN_W-1:0] len;
        logic                 held_next;
    } run_t;

    function automatic logic [RUN_LEN_W-1:0] ent_len(entity_t ent);
        logic [RUN_LEN_W-1:0] n;
        n = '0;
        case (ent)
            ENT_NONE:  n = 3'd0;
            ENT_PLAIN: n = 3'd1;
            ENT_QUOT:  n = 3'd6;
            ENT_APOS:  n = 3'd6;
            ENT_LT:    n = 3'd4;
            ENT_GT:    n = 3'd4;
            ENT_AMP:   n = 3'd5;
            ENT_NBSP:  n = 3'd6;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // Byte at position pos of an entity; text is left aligned
    function automatic logic [7:0] ent_byte(entity_t ent, logic [7:0] plain,
                                            logic [RUN_LEN_W-1:0] pos);
        logic [8*ENT_MAX_BYTES-1:0] text;
        logic [8*ENT_MAX_BYTES-1:0] shifted;
        text = '0;
        case (ent)
            ENT_PLAIN: text = {plain, 48'h0};
            ENT_QUOT:  text = {"&quot;", 8'h0};
            ENT_APOS:  text = {"&#039;", 8'h0};
            ENT_LT:    text = {"&lt;", 24'h0};
            ENT_GT:    text = {"&gt;", 24'h0};
            ENT_AMP:   text = {"&amp;", 16'h0};
            ENT_NBSP:  text = {"&nbsp;", 8'h0};
            default:   text = '0;
        endcase
        shifted = text << {pos, 3'b000};
        return shifted[8*ENT_MAX_BYTES-1 -: 8];
    endfunction

endpackage

>>> rtl/hsce_if.sv
interface hsce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       string_last;

    modport source (output valid, output text_byte, output string_last, input ready);
    modport sink   (input valid, input text_byte, input string_last, output ready);
endinterface

interface hsce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    output ready);
endinterface

interface hsce_cfg_if;
    import hsce_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/hsce_classify.sv
module hsce_classify (
    input  hsce_pkg::cfg_t  cfg,
    input  hsce_pkg::item_t item,
    output hsce_pkg::run_t  run
);
    import hsce_pkg::*;

    logic    pair_mode;
    logic    hold_this;
    entity_t single_ent;

    assign pair_mode = cfg.utf8_mode & cfg.esc_nbsp;
    assign hold_this = (item.text_byte == LEAD_BYTE) & pair_mode & ~item.string_last;

    // Escape of a byte on its own
    always_comb
    begin
        case (item.text_byte)
            CHR_DQUOTE: single_ent = cfg.esc_dquote ? ENT_QUOT : ENT_PLAIN;
            CHR_SQUOTE: single_ent = cfg.esc_squote ? ENT_APOS : ENT_PLAIN;
            CHR_LT:     single_ent = ENT_LT;
            CHR_GT:     single_ent = ENT_GT;
            CHR_AMP:    single_ent = ENT_AMP;
            NBSP_BYTE:  single_ent = (cfg.esc_nbsp & ~cfg.utf8_mode) ? ENT_NBSP : ENT_PLAIN;
            default:    single_ent = ENT_PLAIN;
        endcase
    end

    // Pair handling around a held lead byte
    always_comb
    begin
        run.lead      = 1'b0;
        run.ent       = single_ent;
        run.held_next = 1'b0;
        if (item.held && pair_mode && item.text_byte == NBSP_BYTE)
        begin
            run.ent = ENT_NBSP;
        end
        else
        begin
            run.lead = item.held;
            if (hold_this)
            begin
                run.ent       = ENT_NONE;
                run.held_next = 1'b1;
            end
        end
        run.len = ent_len(run.ent) + {{(RUN_LEN_W-1){1'b0}}, run.lead};
    end

endmodule

>>> rtl/hsce_expand.sv
module hsce_expand (
    input  logic              clk,
    input  logic              rst_n,
    hsce_in_if.sink           text_in,
    hsce_out_if.source        text_out,
    output hsce_pkg::item_t   item,
    input  hsce_pkg::run_t    run
);
    import hsce_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 held_reg;
    logic [RUN_LEN_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_run_last_reg;
    logic                 out_end_reg;

    logic                 out_free;
    logic                 emit;
    logic                 at_end;
    logic                 done;
    logic                 accept;
    logic [RUN_LEN_W-1:0] pos;
    logic [7:0]           byte_next;

    assign item.text_byte   = byte_reg;
    assign item.string_last = last_reg;
    assign item.held        = held_reg;

    // Handshake and sequencing through the run
    assign out_free      = ~out_valid_reg | text_out.ready;
    assign emit          = in_valid_reg & (run.len != '0) & out_free;
    assign at_end        = (idx_reg == run.len - 3'd1);
    assign done          = in_valid_reg & ((run.len == '0) | (emit & at_end));
    assign text_in.ready = ~in_valid_reg | done;
    assign accept        = text_in.valid & text_in.ready;

    // Byte for the current position of the run
    assign pos       = idx_reg - {{(RUN_LEN_W-1){1'b0}}, run.lead};
    assign byte_next = (run.lead && idx_reg == '0) ? LEAD_BYTE
                                                   : ent_byte(run.ent, byte_reg, pos);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            held_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (done)
                in_valid_reg <= 1'b0;

            if (done)
            begin
                held_reg <= run.held_next;
                idx_reg  <= '0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 3'd1;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (text_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text_in.text_byte;
            last_reg <= text_in.string_last;
        end
        if (emit)
        begin
            out_byte_reg     <= byte_next;
            out_run_last_reg <= at_end;
            out_end_reg      <= at_end & last_reg;
        end
    end

    assign text_out.valid      = out_valid_reg;
    assign text_out.out_byte   = out_byte_reg;
    assign text_out.run_last   = out_run_last_reg;
    assign text_out.string_end = out_end_reg;

endmodule

>>> rtl/html_special_char_escaper.sv
// HTML special-character escaper.
//
// text_in takes one text byte per item with string_last on the final byte
// of a string. text_out gives the escaped bytes, one per item, with run_last
// on the last byte caused by an input item and string_end on the last byte
// of the string. cfg writes the four one-bit control registers (index 0..3,
// others ignored); it is always ready and must be used only while idle.
//
// Each input item is held in the input register while its output bytes
// pass one by one through the single output register; a plain byte gives
// one output byte, an entity as many bytes as it has (up to 7 with a flushed
// C2 lead byte). The next item is taken as the last byte of a run is sent.
// A C2 held for pairing gives no output.
// A stalled receiver holds the output register and backs up into text_in.
// Reset empties both registers, clears the held lead byte and loads the
// register defaults: quote escape on, apostrophe escape off, UTF-8 mode on,
// nbsp escape off.
module html_special_char_escaper (
    input  logic       clk,
    input  logic       rst_n,
    hsce_cfg_if.sink   cfg,
    hsce_in_if.sink    text_in,
    hsce_out_if.source text_out
);
    import hsce_pkg::*;

    cfg_t  cfg_reg;
    item_t item;
    run_t  run;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.esc_dquote <= 1'b1;
            cfg_reg.esc_squote <= 1'b0;
            cfg_reg.utf8_mode  <= 1'b1;
            cfg_reg.esc_nbsp   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ESC_DQUOTE: cfg_reg.esc_dquote <= cfg.data;
                CFG_ESC_SQUOTE: cfg_reg.esc_squote <= cfg.data;
                CFG_UTF8_MODE:  cfg_reg.utf8_mode  <= cfg.data;
                CFG_ESC_NBSP:   cfg_reg.esc_nbsp   <= cfg.data;
                default:        ;
            endcase
        end
    end

    hsce_classify u_classify (
        .cfg  (cfg_reg),
        .item (item),
        .run  (run)
    );

    hsce_expand u_expand (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .text_out (text_out),
        .item     (item),
        .run      (run)
    );

endmodule
